// File: rtl/core/dfp_pkg.sv
// Shared types, constants and the PM2.5 index table for the dust frame parser.
package dfp_pkg;

  localparam logic [7:0] START_BYTE = 8'h42;
  localparam logic [4:0] FRAME_LAST = 5'd31;
  localparam logic [4:0] SUM_BYTES  = 5'd30;
  localparam int         NUM_WORDS  = 6;

  localparam logic [15:0] GOOD_MAX      = 16'd25;
  localparam logic [15:0] MODERATE_MAX  = 16'd37;
  localparam logic [15:0] SENSITIVE_MAX = 16'd50;
  localparam logic [15:0] UNHEALTHY_MAX = 16'd90;
  localparam logic [7:0]  AQI_MAX       = 8'd201;

  typedef enum logic [2:0] {
    BAND_GOOD      = 3'd0,
    BAND_MODERATE  = 3'd1,
    BAND_SENSITIVE = 3'd2,
    BAND_UNHEALTHY = 3'd3,
    BAND_HAZARDOUS = 3'd4
  } air_band_t;

  // End-of-frame status from the parser.
  typedef struct packed {
    logic                          done;
    logic                          ok;
    logic [NUM_WORDS-1:0][15:0]    words;
  } frame_result_t;

  typedef logic [7:0] aqi_table_t [0:90];

  function automatic aqi_table_t build_aqi_table();
    aqi_table_t t;
    for (int p = 0; p <= 90; p++) begin
      if (p <= 25) begin
        t[p] = 8'(p);
      end else if (p <= 37) begin
        t[p] = 8'((p - 26) * 24 / 11 + 26);
      end else if (p <= 50) begin
        t[p] = 8'((p - 38) * 49 / 12 + 51);
      end else begin
        t[p] = 8'((p - 51) * 99 / 39 + 101);
      end
    end
    return t;
  endfunction

  localparam aqi_table_t AQI_TABLE = build_aqi_table();

endpackage

// File: rtl/core/dust_frame_parser_aqi.sv
// Top level of the dust frame parser: input register, parser, grader, result register.
// Takes one sensor byte per cycle and gives one result word at the end of each
// 32-byte frame that starts with 0x42; bytes before a start byte are dropped.
// Each byte is held in the input register and parsed into the result register
// as it leaves, so a frame's result is registered as its last byte leaves the
// input register. Throughput is one byte per cycle, limited only by out_stall. A
// failed checksum still gives a result, with checksum_ok low and the band and
// index of the last good frame.
module dust_frame_parser_aqi (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        checksum_ok,
  output logic [15:0] pm1_standard,
  output logic [15:0] pm25_std,
  output logic [15:0] pm10_std,
  output logic [15:0] pm1_environment,
  output logic [15:0] pm25_environment,
  output logic [15:0] pm10_environment,
  output logic [2:0]  air_band,
  output logic [7:0]  air_index
);
  import dfp_pkg::*;

  logic          byte_valid;
  logic [7:0]    byte_q;
  logic          advance;
  logic          step;
  frame_result_t fr;
  air_band_t     band_now;
  logic [7:0]    index_now;

  assign advance  = !out_valid || !out_stall;
  assign step     = byte_valid && advance;
  assign in_stall = byte_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      byte_valid <= 1'b1;
    end else if (step) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_q <= rx_byte;
    end
  end

  dfp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (byte_q),
    .result  (fr)
  );

  dfp_grade u_grade (
    .clk    (clk),
    .rst    (rst),
    .update (fr.done && fr.ok),
    .pm25   (fr.words[4]),
    .band   (band_now),
    .index  (index_now)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fr.done;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fr.done) begin
      checksum_ok      <= fr.ok;
      pm1_standard     <= fr.words[0];
      pm25_std         <= fr.words[1];
      pm10_std         <= fr.words[2];
      pm1_environment  <= fr.words[3];
      pm25_environment <= fr.words[4];
      pm10_environment <= fr.words[5];
      air_band         <= band_now;
      air_index        <= index_now;
    end
  end

  a_no_step_blocked: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !step)
    else $error("byte processed while result word blocked");

  a_done_gives_word: assert property (@(posedge clk) disable iff (rst)
    step && fr.done |=> out_valid)
    else $error("frame end did not produce a result word");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> byte_valid)
    else $error("input stalled with empty input register");

  a_band_index: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((air_band == BAND_GOOD) == (air_index <= 8'd25)))
    else $error("air band and index disagree");

endmodule

// File: rtl/core/dfp_parser.sv
// Frame hunter, byte counter, checksum accumulator and word capture.
module dfp_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [7:0]             rx_byte,
  output dfp_pkg::frame_result_t result
);
  import dfp_pkg::*;

  logic                 in_frame;
  logic [4:0]           byte_count;
  logic [15:0]          running_sum;
  logic [7:0]           high_byte_hold;
  logic [NUM_WORDS-1:0][15:0] words;
  logic [15:0]          word_now;

  assign word_now = {high_byte_hold, rx_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      byte_count     <= '0;
      running_sum    <= '0;
      high_byte_hold <= '0;
    end else if (step) begin
      if (!in_frame) begin
        if (rx_byte == START_BYTE) begin
          in_frame       <= 1'b1;
          byte_count     <= 5'd1;
          running_sum    <= {8'd0, rx_byte};
          high_byte_hold <= rx_byte;
        end
      end else begin
        if (byte_count < SUM_BYTES) begin
          running_sum <= running_sum + {8'd0, rx_byte};
        end
        if (!byte_count[0]) begin
          high_byte_hold <= rx_byte;
          byte_count     <= byte_count + 5'd1;
        end else if (byte_count == FRAME_LAST) begin
          in_frame    <= 1'b0;
          byte_count  <= '0;
          running_sum <= '0;
        end else begin
          byte_count <= byte_count + 5'd1;
        end
      end
    end
  end

  // word i (PM fields) completes on odd byte 5 + 2i
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      if (step && in_frame && byte_count == 5'(5 + 2 * i)) begin
        words[i] <= word_now;
      end
    end
  end

  assign result.done  = step && in_frame && (byte_count == FRAME_LAST);
  assign result.ok    = (running_sum == word_now);
  assign result.words = words;

endmodule

// File: rtl/core/dfp_grade.sv
// PM2.5 air quality band and index, held from the last good frame.
module dfp_grade (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  update,
  input  logic [15:0]           pm25,
  output dfp_pkg::air_band_t    band,
  output logic [7:0]            index
);
  import dfp_pkg::*;

  air_band_t  held_band;
  logic [7:0] held_index;
  air_band_t  graded_band;
  logic [7:0] graded_index;

  always_comb begin
    if (pm25 <= GOOD_MAX) begin
      graded_band = BAND_GOOD;
    end else if (pm25 <= MODERATE_MAX) begin
      graded_band = BAND_MODERATE;
    end else if (pm25 <= SENSITIVE_MAX) begin
      graded_band = BAND_SENSITIVE;
    end else if (pm25 <= UNHEALTHY_MAX) begin
      graded_band = BAND_UNHEALTHY;
    end else begin
      graded_band = BAND_HAZARDOUS;
    end
    if (pm25 <= UNHEALTHY_MAX) begin
      graded_index = AQI_TABLE[pm25[6:0]];
    end else begin
      graded_index = AQI_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_band  <= BAND_GOOD;
      held_index <= '0;
    end else if (update) begin
      held_band  <= graded_band;
      held_index <= graded_index;
    end
  end

  assign band  = update ? graded_band  : held_band;
  assign index = update ? graded_index : held_index;

endmodule

// File: test/tb_dust_frame_parser_aqi.sv
`timescale 1ns / 100ps
// Self-checking testbench for the dust frame parser: directed frames, random traffic, backpressure.
module tb_dust_frame_parser_aqi;
  import dfp_pkg::*;

  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES     = 8;

  typedef struct packed {
    logic             ok;
    logic [5:0][15:0] pm;
    air_band_t        band;
    logic [7:0]       aqi;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        checksum_ok;
  logic [15:0] pm1_standard;
  logic [15:0] pm25_std;
  logic [15:0] pm10_std;
  logic [15:0] pm1_environment;
  logic [15:0] pm25_environment;
  logic [15:0] pm10_environment;
  logic [2:0]  air_band;
  logic [7:0]  air_index;

  int  errors = 0;
  int  idle_cycles = 0;
  int  sent_bytes = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_pending = 1'b0;

  reading_t pending_readings[$];

  // shadow parser state
  bit          sh_in_frame = 1'b0;
  logic [4:0]  sh_count = '0;
  logic [15:0] sh_sum = '0;
  logic [7:0]  sh_high = '0;
  logic [15:0] sh_words [0:6];
  air_band_t   sh_band = BAND_GOOD;
  logic [7:0]  sh_aqi = '0;

  dust_frame_parser_aqi i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .checksum_ok      (checksum_ok),
    .pm1_standard     (pm1_standard),
    .pm25_std         (pm25_std),
    .pm10_std         (pm10_std),
    .pm1_environment  (pm1_environment),
    .pm25_environment (pm25_environment),
    .pm10_environment (pm10_environment),
    .air_band         (air_band),
    .air_index        (air_index)
  );

  always #10 clk = ~clk;

  function automatic void grade_pm25_index(input logic [15:0] p, output air_band_t band,
                                           output logic [7:0] aqi);
    int v;
    v = int'(p);
    if (p <= GOOD_MAX) begin
      band = BAND_GOOD;
      aqi  = 8'(v);
    end else if (p <= MODERATE_MAX) begin
      band = BAND_MODERATE;
      aqi  = 8'((v - 26) * 24 / 11 + 26);
    end else if (p <= SENSITIVE_MAX) begin
      band = BAND_SENSITIVE;
      aqi  = 8'((v - 38) * 49 / 12 + 51);
    end else if (p <= UNHEALTHY_MAX) begin
      band = BAND_UNHEALTHY;
      aqi  = 8'((v - 51) * 99 / 39 + 101);
    end else begin
      band = BAND_HAZARDOUS;
      aqi  = AQI_MAX;
    end
  endfunction

  function automatic void parse_sensor_byte(input logic [7:0] b);
    reading_t    r;
    logic [15:0] w;
    if (!sh_in_frame) begin
      if (b == START_BYTE) begin
        sh_in_frame = 1'b1;
        sh_count    = 5'd1;
        sh_sum      = {8'h00, b};
        sh_high     = b;
      end
      return;
    end
    if (sh_count < SUM_BYTES) sh_sum = sh_sum + {8'h00, b};
    if (!sh_count[0]) begin
      sh_high  = b;
      sh_count = sh_count + 5'd1;
      return;
    end
    w = {sh_high, b};
    if (sh_count >= 5'd3 && sh_count <= 5'd15) sh_words[3'((sh_count - 5'd3) >> 1)] = w;
    if (sh_count != FRAME_LAST) begin
      sh_count = sh_count + 5'd1;
      return;
    end
    r.ok = (sh_sum == w);
    if (r.ok) grade_pm25_index(sh_words[5], sh_band, sh_aqi);
    for (int j = 0; j < 6; j++) r.pm[j] = sh_words[j + 1];
    r.band = sh_band;
    r.aqi  = sh_aqi;
    pending_readings.push_back(r);
    sh_in_frame = 1'b0;
    sh_count    = '0;
    sh_sum      = '0;
  endfunction

  task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endtask

  task automatic check_reading();
    reading_t r;
    if (pending_readings.size() == 0) begin
      errors++;
      $display("%0t: unexpected result word, expected none, actual pm25_environment %h",
               $time, pm25_environment);
      return;
    end
    r = pending_readings.pop_front();
    check_field("checksum_ok", 16'(r.ok), 16'(checksum_ok));
    check_field("pm1_standard", r.pm[0], pm1_standard);
    check_field("pm25_std", r.pm[1], pm25_std);
    check_field("pm10_std", r.pm[2], pm10_std);
    check_field("pm1_environment", r.pm[3], pm1_environment);
    check_field("pm25_environment", r.pm[4], pm25_environment);
    check_field("pm10_environment", r.pm[5], pm10_environment);
    check_field("air_band", 16'(r.band), 16'(air_band));
    check_field("air_index", 16'(r.aqi), 16'(air_index));
  endtask

  // accepted bytes, result checking and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (in_valid && !in_stall) parse_sensor_byte(rx_byte);
      if (out_valid && !out_stall) check_reading();
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_frame(input logic [5:0][15:0] pm, input logic [7:0] second, input bit good);
    logic [7:0]  fb [0:31];
    logic [15:0] sum;
    logic [15:0] csum;
    fb[0] = START_BYTE;
    fb[1] = second;
    for (int i = 2; i < 30; i++) fb[i] = 8'($urandom_range(255));
    for (int j = 0; j < 6; j++) begin
      fb[4 + 2 * j] = pm[j][15:8];
      fb[5 + 2 * j] = pm[j][7:0];
    end
    sum = '0;
    for (int i = 0; i < 30; i++) sum = sum + {8'h00, fb[i]};
    csum = good ? sum : sum ^ 16'($urandom_range(1, 65535));
    fb[30] = csum[15:8];
    fb[31] = csum[7:0];
    for (int i = 0; i < 32; i++) send_byte(fb[i]);
  endtask

  function automatic logic [5:0][15:0] random_pm(input bit banded);
    logic [5:0][15:0] pm;
    for (int j = 0; j < 6; j++) pm[j] = 16'($urandom_range(65535));
    if (banded) pm[4] = 16'($urandom_range(0, 100));
    return pm;
  endfunction

  task automatic send_noise(input int n, input bit allow_start);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(255));
      if (b == START_BYTE && !allow_start) b = 8'h41;
      send_byte(b);
    end
  endtask

  task automatic test_bad_checksum_before_good();
    logic [5:0][15:0] pm;
    pm    = random_pm(1'b0);
    pm[4] = 16'd40;
    send_frame(pm, 8'h4d, 1'b0);
  endtask

  task automatic test_aqi_bands();
    logic [15:0]      edges [0:9];
    logic [5:0][15:0] pm;
    edges = '{16'd0, 16'd25, 16'd26, 16'd37, 16'd38, 16'd50, 16'd51, 16'd90, 16'd91,
              16'hffff};
    foreach (edges[i]) begin
      pm    = random_pm(1'b0);
      pm[4] = edges[i];
      send_frame(pm, 8'h4d, 1'b1);
    end
  endtask

  task automatic test_field_extremes();
    send_frame({6{16'h0000}}, 8'h00, 1'b1);
    send_frame({6{16'hffff}}, 8'hff, 1'b1);
  endtask

  task automatic test_bad_checksum_hold();
    logic [5:0][15:0] pm;
    pm    = random_pm(1'b0);
    pm[4] = 16'd60;
    send_frame(pm, 8'h4d, 1'b1);
    pm    = random_pm(1'b0);
    pm[4] = 16'd10;
    send_frame(pm, 8'h4d, 1'b0);
  endtask

  task automatic test_start_byte_in_frame();
    send_frame({6{16'h4242}}, START_BYTE, 1'b1);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h41);
    send_byte(8'h43);
    send_frame(random_pm(1'b1), 8'h4d, 1'b1);
  endtask

  task automatic test_random_traffic(input int s_pct, input int r_pct, input int nbytes);
    int target;
    int pick;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    target = sent_bytes + nbytes;
    while (sent_bytes < target) begin
      pick = $urandom_range(99);
      if (pick < 70) send_frame(random_pm($urandom_range(99) < 60),
                                8'($urandom_range(255)), 1'b1);
      else if (pick < 82) send_frame(random_pm(1'($urandom_range(1))),
                                     8'($urandom_range(255)), 1'b0);
      else send_noise($urandom_range(1, 8), $urandom_range(3) == 0);
    end
  endtask

  task automatic test_long_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_pending  = 1'b1;
    repeat (5) send_frame(random_pm(1'b1), 8'h4d, 1'b1);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 26;
    recv_idle_pct = 58;
    test_bad_checksum_before_good();
    test_aqi_bands();
    test_field_extremes();
    test_bad_checksum_hold();
    test_start_byte_in_frame();
    test_random_traffic(26, 58, 430);
    test_random_traffic(58, 26, 430);
    test_random_traffic(0, 0, 330);
    test_long_stall();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
